// File: rtl/bmc_pkg.sv
// shared types, codes and helpers for the bracket match checker
`timescale 1ns / 1ps

package bmc_pkg;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REDUNDANT = 3'd1;
    localparam logic [2:0] ST_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_SUCCESS   = 3'd4;
    localparam logic [2:0] ST_UNCLOSED  = 3'd5;
    localparam logic [2:0] ST_HELD      = 3'd6;

    // bracket kinds as stored on the stack
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    // ascii codes of the brackets
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    localparam int DEPTH_W = 6;

    // classified request as it travels from front to back
    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
        logic       last;
    } item_t;

    // closer that a stored kind needs; unknown kinds count as round
    function automatic logic [7:0] closer_of(input logic [1:0] kind);
        logic [7:0] c;
        begin
            c = CH_CLOSE_ROUND;
            if (kind == KIND_SQUARE)
            begin
                c = CH_CLOSE_SQUARE;
            end
            else if (kind == KIND_CURLY)
            begin
                c = CH_CLOSE_CURLY;
            end
            return c;
        end
    endfunction

endpackage

// File: rtl/bmc_in_if.sv
// input channel: one character and its end mark per request
`timescale 1ns / 1ps

interface bmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink (input valid, input ch, input last_char, output ready);
endinterface

// File: rtl/bmc_out_if.sv
// output channel: one check result per request
`timescale 1ns / 1ps

interface bmc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] depth;
    logic [7:0] expected_close;
    logic       done_res;

    modport source (output valid, output status, output depth, output expected_close,
                    output done_res, input ready);
    modport sink (input valid, input status, input depth, input expected_close,
                  input done_res, output ready);
endinterface

// File: rtl/bmc_front.sv
// front end: accepts characters and classifies them into bracket kinds
`timescale 1ns / 1ps

module bmc_front
    import bmc_pkg::*;
(
    bmc_in_if.sink  in_req,
    input  logic    q_ready,
    output logic    q_push,
    output item_t   q_item
);

    // handshake follows queue space
    assign in_req.ready = q_ready;
    assign q_push       = in_req.valid && q_ready;

    // decode opener / closer and kind
    always_comb
    begin
        q_item.is_open  = 1'b0;
        q_item.is_close = 1'b0;
        q_item.kind     = KIND_ROUND;
        q_item.last     = in_req.last_char;
        unique case (in_req.ch)
            CH_OPEN_ROUND:
            begin
                q_item.is_open = 1'b1;
                q_item.kind    = KIND_ROUND;
            end
            CH_OPEN_SQUARE:
            begin
                q_item.is_open = 1'b1;
                q_item.kind    = KIND_SQUARE;
            end
            CH_OPEN_CURLY:
            begin
                q_item.is_open = 1'b1;
                q_item.kind    = KIND_CURLY;
            end
            CH_CLOSE_ROUND:
            begin
                q_item.is_close = 1'b1;
                q_item.kind     = KIND_ROUND;
            end
            CH_CLOSE_SQUARE:
            begin
                q_item.is_close = 1'b1;
                q_item.kind     = KIND_SQUARE;
            end
            CH_CLOSE_CURLY:
            begin
                q_item.is_close = 1'b1;
                q_item.kind     = KIND_CURLY;
            end
            default:
            begin
                q_item.is_open = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bmc_queue.sv
// two-entry queue between front end and stack engine
`timescale 1ns / 1ps

module bmc_queue
    import bmc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    item_t      slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = slot_reg[rp_reg];

    // occupancy update
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && pop_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && pop && pop_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && pop_valid)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

endmodule

// File: rtl/bmc_back.sv
// stack engine: push / pop / compare and the registered result stage
`timescale 1ns / 1ps

module bmc_back
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  item_t     q_item,
    output logic      q_pop,
    bmc_out_if.source out_res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // stack memory holds every entry below the top
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [1:0]    top_reg;
    logic [1:0]    top_next;
    logic [1:0]    below_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_after;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] cnt_m2;
    logic          err_reg;
    logic          err_next;
    logic          err_now;
    logic          fire;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [1:0]    top_eff;
    logic [2:0]    status_c;
    logic [7:0]    expected_c;

    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [5:0]    depth_reg;
    logic [7:0]    expected_reg;
    logic          done_reg;

    assign fire    = q_valid && (!out_valid_reg || out_res.ready);
    assign q_pop   = fire;
    assign cnt_dec = count_reg - CW'(1);
    assign top_eff = (top_reg == 2'd3) ? KIND_ROUND : top_reg;

    // stack step for the request at the queue head
    always_comb
    begin
        count_after = count_reg;
        top_next    = top_reg;
        err_now     = 1'b0;
        status_c    = ST_OK;
        expected_c  = 8'd0;
        mem_we      = 1'b0;
        mem_waddr   = cnt_dec[AW-1:0];
        if (err_reg)
        begin
            status_c = ST_HELD;
        end
        else if (q_item.is_open)
        begin
            if (count_reg == CW'(STACK_DEPTH))
            begin
                status_c = ST_OVERFLOW;
                err_now  = 1'b1;
            end
            else
            begin
                mem_we      = (count_reg != '0);
                top_next    = q_item.kind;
                count_after = count_reg + CW'(1);
            end
        end
        else if (q_item.is_close)
        begin
            if (count_reg == '0)
            begin
                status_c = ST_REDUNDANT;
                err_now  = 1'b1;
            end
            else
            begin
                top_next    = below_reg;
                count_after = cnt_dec;
                if (top_eff != q_item.kind)
                begin
                    status_c   = ST_MISMATCH;
                    expected_c = closer_of(top_eff);
                    err_now    = 1'b1;
                end
            end
        end
        if (q_item.last && !err_reg && !err_now)
        begin
            status_c = (count_after == '0) ? ST_SUCCESS : ST_UNCLOSED;
        end
    end

    // committed state, cleared at the end mark
    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (fire)
        begin
            count_next = q_item.last ? '0 : count_after;
            err_next   = q_item.last ? 1'b0 : (err_reg || err_now);
        end
    end

    // keep the entry under the new top prefetched
    assign cnt_m2    = count_next - CW'(2);
    assign mem_raddr = cnt_m2[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (fire && mem_we)
        begin
            stack_mem[mem_waddr] <= top_reg;
        end
        if (fire && mem_we && (mem_waddr == mem_raddr))
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= stack_mem[mem_raddr];
        end
        if (fire)
        begin
            top_reg <= top_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_c;
            depth_reg    <= DEPTH_W'(count_after);
            expected_reg <= expected_c;
            done_reg     <= q_item.last;
        end
    end

    assign out_res.valid          = out_valid_reg;
    assign out_res.status         = status_reg;
    assign out_res.depth          = depth_reg;
    assign out_res.expected_close = expected_reg;
    assign out_res.done_res       = done_reg;

    // stack count never passes the capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above capacity");

    // end mark leaves a clean engine
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && q_item.last) |=> (count_reg == '0 && !err_reg))
        else $error("state not cleared after end mark");

    // a held error reports held and leaves the stack alone
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err_reg && !q_item.last) |=> (status_reg == ST_HELD && $stable(count_reg)))
        else $error("held error not reported");

    // mismatch is the only result with a closer attached
    a_expected: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status_c != ST_MISMATCH) |-> (expected_c == 8'd0))
        else $error("closer reported without mismatch");

endmodule

// File: rtl/bracket_match_checker.sv
// top level of the bracket match checker: front end, queue and stack engine
// path: an accepted request is first held in the queue; when the stack engine takes it from
//   the queue head, the stack step lands in the result register
// throughput: one character per cycle while out_res is not stalled; the top of stack sits in a register and
//   the entry below it is prefetched from the stack memory, so push and pop do not hold the flow
// reset: rst_n clears the queue, stack count, error flag and result valid;
//   the stack memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module bracket_match_checker
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    bmc_in_if.sink    in_req,
    bmc_out_if.source out_res
);

    logic  q_push;
    logic  q_ready;
    item_t q_in_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_out_item;

    // classify incoming characters
    bmc_front u_front (
        .in_req  (in_req),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    // decouple front end and stack engine
    bmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out_item)
    );

    // stack engine and result stage
    bmc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_out_item),
        .q_pop   (q_pop),
        .out_res (out_res)
    );

endmodule
